@@ rtl/msh_pkg.sv @@
package msh_pkg;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int MW        = 34;
    localparam int PW        = 2 * MW;
    localparam int PSW       = PW - FB;
    localparam int DVD_W     = 51;
    localparam int DVS_W     = 34;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 2;
    localparam int NQ        = 3;

    typedef logic signed [DW-1:0]   data_t;
    typedef logic signed [DW+1:0]   wide_t;

    typedef struct packed {
        logic  flag;
        data_t val;
    } sat_res_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    localparam logic [CFG_IDX_W-1:0] REG_OMEGA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HDX   = 2'd2;

    localparam data_t DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam data_t DMIN = {1'b1, {(DW-1){1'b0}}};
    localparam wide_t WMAX = {2'b00, DMAX};
    localparam wide_t WMIN = {2'b11, DMIN};

    function automatic wide_t wext(input data_t x);
        return {{2{x[DW-1]}}, x};
    endfunction

    function automatic logic [MW-1:0] mag_of(input logic signed [MW-1:0] x);
        return x[MW-1] ? unsigned'(-x) : unsigned'(x);
    endfunction

    // Saturate a magnitude with a sign into the data range.
    function automatic sat_res_t sat_mag(input logic [PSW-1:0] p, input logic neg);
        sat_res_t        r;
        logic [PSW-1:0]  hi;
        hi     = {{(PSW-DW){1'b0}}, DMAX};
        r.flag = 1'b0;
        if (neg) begin
            if (p > hi) begin
                r.flag = (p > hi + 1'b1);
                r.val  = DMIN;
            end
            else begin
                r.val = data_t'(~p[DW-1:0] + 1'b1);
            end
        end
        else if (p > hi) begin
            r.flag = 1'b1;
            r.val  = DMAX;
        end
        else begin
            r.val = data_t'(p[DW-1:0]);
        end
        return r;
    endfunction

    function automatic sat_res_t sat_wide(input wide_t v);
        sat_res_t r;
        r.flag = 1'b0;
        if (v > WMAX) begin
            r.flag = 1'b1;
            r.val  = DMAX;
        end
        else if (v < WMIN) begin
            r.flag = 1'b1;
            r.val  = DMIN;
        end
        else begin
            r.val = data_t'(v[DW-1:0]);
        end
        return r;
    endfunction

endpackage

@@ rtl/msh_ifs.sv @@
interface msh_cell_if import msh_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  first_cell;
    data_t density;
    data_t momentum;
    data_t energy;

    modport source (output valid, first_cell, density, momentum, energy, input ready);
    modport sink   (input valid, first_cell, density, momentum, energy, output ready);
endinterface

interface msh_face_if import msh_pkg::*; ();
    logic  valid;
    logic  ready;
    data_t density_left;
    data_t density_right;
    data_t momentum_left;
    data_t momentum_right;
    data_t energy_left;
    data_t energy_right;
    logic  fault;

    modport source (output valid, density_left, density_right, momentum_left,
                    momentum_right, energy_left, energy_right, fault, input ready);
    modport sink   (input valid, density_left, density_right, momentum_left,
                    momentum_right, energy_left, energy_right, fault, output ready);
endinterface

@@ rtl/msh_div.sv @@
module msh_div import msh_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output div_stat_t        stat,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVS_W-1:0] rem_reg;
    logic [DVD_W-1:0] quo_reg;
    logic [DVS_W-1:0] dvs_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             ge;
    logic [DVS_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dvs_reg  <= divisor;
                cnt_reg  <= CNT_W'(DVD_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[DVD_W-2:0], ge};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ rtl/muscl_hancock_cell_predictor.sv @@
// Per centre-forming item: each slope runs difference, two multiplies, the shared serial
// divider, a multiply and a finish step, or goes straight to its faces when it is zero;
// each face flux divides for velocity, skipped when its density is not positive, then
// multiplies; the half-step update follows, then the hand-over to the output register.
// Only one item is in work at a time; a finished result waits while the output register
// is full. Cells that only fill the window are taken directly in the idle state.
// Reset: window count, sequencer, output valid and settings registers return to defaults.
module muscl_hancock_cell_predictor import msh_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    msh_cell_if.sink             cell_in,
    msh_face_if.source           face_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_SL_DIFF, ST_SL_M1, ST_SL_M2, ST_SL_DIVGO, ST_SL_DIVW, ST_SL_M3,
        ST_SL_FIN, ST_SL_FACE, ST_FX_VEL, ST_FX_VW, ST_FX_RU, ST_FX_RU2, ST_FX_KE,
        ST_FX_KE2, ST_FX_HK, ST_FX_P, ST_FX_P2, ST_FX_FM, ST_FX_FE, ST_FX_FE2,
        ST_DL_SUB, ST_DL_M, ST_DL_M2, ST_DL_OUT, ST_DONE
    } state_t;

    localparam logic signed [CFG_W-1:0] ONE_W = CFG_W'(1 << FB);

    state_t                  state_reg;
    logic [1:0]              k_reg;
    logic                    side_reg;
    logic [1:0]              cnt_reg;
    logic signed [CFG_W-1:0] omega_reg;
    logic [CFG_W-1:0]        gm_reg;
    logic [CFG_W-2:0]        hdx_reg;

    data_t win0_reg [NQ];
    data_t win1_reg [NQ];
    data_t cur_reg  [NQ];
    data_t lf_reg   [NQ];
    data_t rf_reg   [NQ];
    data_t fl_reg   [NQ];
    data_t fr_reg   [NQ];
    data_t rl_reg   [NQ];
    data_t rr_reg   [NQ];

    logic [DW:0]      a_mag_reg;
    logic [DW:0]      b_mag_reg;
    logic             neg_reg;
    logic [PW-1:0]    acc_reg;
    logic [PW-1:0]    prod_reg;
    logic             mneg_reg;
    logic [CFG_W-1:0] q_reg;
    data_t            hs_reg;
    data_t            u_reg;
    data_t            ru_reg;
    data_t            ke_reg;
    data_t            p_reg;
    data_t            tmp_reg;
    logic             fault_reg;

    logic  ovalid_reg;
    data_t o_dl_reg, o_dr_reg, o_ml_reg, o_mr_reg, o_el_reg, o_er_reg;
    logic  o_f_reg;

    // shared divider
    logic             div_start;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    div_stat_t        div_stat;
    logic [DVD_W-1:0] div_quo;

    msh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    logic signed [CFG_W-1:0] w_cl;
    logic [CFG_W-1:0]        opw, omw;
    wide_t                   a_d, b_d;
    logic [DW:0]             a_mag, b_mag;
    data_t                   fa_r, fa_m, fa_e;
    logic [DW-1:0]           fm_mag, ke_mag;
    logic signed [MW-1:0]    mx, my;
    sat_res_t                mres, vres, hk, s_ehk, s_kep, s_ep, s_dlt;
    sat_res_t                s_lf, s_rf, s_ol, s_or;
    logic [PSW-1:0]          ml;
    logic [DW:0]             m_min;
    logic [DW-1:0]           m_half;
    logic                    cell_acc;
    logic [1:0]              cnt_eff;

    function automatic logic [DW:0] low_mag(input wide_t v);
        return v[DW:0];
    endfunction

    always_comb
    begin
        if (omega_reg > ONE_W)
            w_cl = ONE_W;
        else if (omega_reg < -ONE_W)
            w_cl = -ONE_W;
        else
            w_cl = omega_reg;
        opw = unsigned'(ONE_W + w_cl);
        omw = unsigned'(ONE_W - w_cl);

        a_d   = wext(win1_reg[k_reg]) - wext(win0_reg[k_reg]);
        b_d   = wext(cur_reg[k_reg]) - wext(win1_reg[k_reg]);
        a_mag = a_d[DW+1] ? low_mag(-a_d) : low_mag(a_d);
        b_mag = b_d[DW+1] ? low_mag(-b_d) : low_mag(b_d);

        fa_r = side_reg ? rf_reg[0] : lf_reg[0];
        fa_m = side_reg ? rf_reg[1] : lf_reg[1];
        fa_e = side_reg ? rf_reg[2] : lf_reg[2];
        fm_mag = fa_m[DW-1] ? unsigned'(-fa_m) : unsigned'(fa_m);
        ke_mag = ke_reg[DW-1] ? unsigned'(-ke_reg) : unsigned'(ke_reg);

        mx = '0;
        my = '0;
        unique case (state_reg)
            ST_SL_M1: begin mx = MW'(opw);   my = MW'(a_mag_reg); end
            ST_SL_M2: begin mx = MW'(omw);   my = MW'(b_mag_reg); end
            ST_SL_M3: begin mx = MW'(q_reg); my = MW'(a_mag_reg); end
            ST_FX_RU: begin mx = MW'(fa_r);   my = MW'(u_reg); end
            ST_FX_KE: begin mx = MW'(ru_reg); my = MW'(u_reg); end
            ST_FX_P:  begin mx = MW'(gm_reg); my = MW'(tmp_reg); end
            ST_FX_FE: begin mx = MW'(u_reg);  my = MW'(tmp_reg); end
            ST_DL_M:  begin mx = MW'(hdx_reg); my = MW'(tmp_reg); end
            default:  begin mx = '0; my = '0; end
        endcase

        mres  = sat_mag(prod_reg[PW-1:FB], mneg_reg && (prod_reg[PW-1:FB] != '0));
        vres  = sat_mag(PSW'(div_quo), fa_m[DW-1]);
        hk    = sat_mag(PSW'(ke_mag >> 1), ke_reg[DW-1]);
        s_ehk = sat_wide(wext(fa_e) - wext(hk.val));
        s_kep = sat_wide(wext(ke_reg) + wext(p_reg));
        s_ep  = sat_wide(wext(fa_e) + wext(p_reg));
        s_dlt = sat_wide(wext(fl_reg[k_reg]) - wext(fr_reg[k_reg]));
        s_lf  = sat_wide(wext(win1_reg[k_reg]) - wext(hs_reg));
        s_rf  = sat_wide(wext(win1_reg[k_reg]) + wext(hs_reg));
        s_ol  = sat_wide(wext(lf_reg[k_reg]) + wext(p_reg));
        s_or  = sat_wide(wext(rf_reg[k_reg]) + wext(p_reg));

        ml     = prod_reg[PW-1:FB];
        m_min  = (ml < PSW'(b_mag_reg)) ? ml[DW:0] : b_mag_reg;
        m_half = m_min[DW:1];

        div_start = (state_reg == ST_SL_DIVGO) ||
                    ((state_reg == ST_FX_VEL) && (fa_r > 0));
        if (state_reg == ST_SL_DIVGO)
        begin
            div_dvd = DVD_W'(acc_reg + prod_reg);
            div_dvs = {1'b0, a_mag_reg} + {1'b0, b_mag_reg};
        end
        else
        begin
            div_dvd = DVD_W'({fm_mag, {FB{1'b0}}});
            div_dvs = DVS_W'(unsigned'(fa_r));
        end

        cell_acc = cell_in.valid && cell_in.ready;
        cnt_eff  = cell_in.first_cell ? 2'd0 : cnt_reg;
    end

    assign cell_in.ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk)
    begin
        prod_reg <= mag_of(mx) * mag_of(my);
        mneg_reg <= mx[MW-1] ^ my[MW-1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            k_reg      <= '0;
            side_reg   <= 1'b0;
            cnt_reg    <= '0;
            omega_reg  <= '0;
            gm_reg     <= CFG_W'(26214);
            hdx_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_OMEGA: omega_reg <= signed'(cfg_data);
                    REG_GAMMA: gm_reg    <= cfg_data;
                    REG_HDX:   hdx_reg   <= cfg_data[CFG_W-2:0];
                    default:   ;
                endcase
            end

            if (ovalid_reg && face_out.ready && (state_reg != ST_DONE))
                ovalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cell_acc)
                    begin
                        if (cnt_eff == 2'd2)
                        begin
                            cur_reg[0] <= cell_in.density;
                            cur_reg[1] <= cell_in.momentum;
                            cur_reg[2] <= cell_in.energy;
                            k_reg      <= '0;
                            fault_reg  <= 1'b0;
                            state_reg  <= ST_SL_DIFF;
                        end
                        else
                        begin
                            // fill the window only
                            win0_reg    <= win1_reg;
                            win1_reg[0] <= cell_in.density;
                            win1_reg[1] <= cell_in.momentum;
                            win1_reg[2] <= cell_in.energy;
                            cnt_reg     <= cnt_eff + 1'b1;
                        end
                    end
                end
                ST_SL_DIFF:
                begin
                    if (a_d == '0 || b_d == '0 || (a_d[DW+1] != b_d[DW+1]))
                    begin
                        hs_reg    <= '0;
                        state_reg <= ST_SL_FACE;
                    end
                    else
                    begin
                        a_mag_reg <= a_mag;
                        b_mag_reg <= b_mag;
                        neg_reg   <= a_d[DW+1];
                        state_reg <= ST_SL_M1;
                    end
                end
                ST_SL_M1:    state_reg <= ST_SL_M2;
                ST_SL_M2:
                begin
                    acc_reg   <= prod_reg;
                    state_reg <= ST_SL_DIVGO;
                end
                ST_SL_DIVGO: state_reg <= ST_SL_DIVW;
                ST_SL_DIVW:
                begin
                    if (div_stat.done)
                    begin
                        q_reg     <= div_quo[CFG_W-1:0];
                        state_reg <= ST_SL_M3;
                    end
                end
                ST_SL_M3:    state_reg <= ST_SL_FIN;
                ST_SL_FIN:
                begin
                    hs_reg    <= neg_reg ? data_t'(~m_half + 1'b1) : data_t'(m_half);
                    state_reg <= ST_SL_FACE;
                end
                ST_SL_FACE:
                begin
                    lf_reg[k_reg] <= s_lf.val;
                    rf_reg[k_reg] <= s_rf.val;
                    fault_reg     <= fault_reg | s_lf.flag | s_rf.flag;
                    if (k_reg == 2'd2)
                    begin
                        side_reg  <= 1'b0;
                        state_reg <= ST_FX_VEL;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_SL_DIFF;
                    end
                end
                ST_FX_VEL:
                begin
                    if (fa_r > 0)
                        state_reg <= ST_FX_VW;
                    else
                    begin
                        // density not positive at this face: flag and drive velocity to its rail
                        fault_reg <= 1'b1;
                        u_reg     <= (fa_m > 0) ? DMAX : (fa_m[DW-1] ? DMIN : '0);
                        state_reg <= ST_FX_RU;
                    end
                end
                ST_FX_VW:
                begin
                    if (div_stat.done)
                    begin
                        u_reg     <= vres.val;
                        fault_reg <= fault_reg | vres.flag;
                        state_reg <= ST_FX_RU;
                    end
                end
                ST_FX_RU:    state_reg <= ST_FX_RU2;
                ST_FX_RU2:
                begin
                    ru_reg    <= mres.val;
                    fault_reg <= fault_reg | mres.flag;
                    state_reg <= ST_FX_KE;
                end
                ST_FX_KE:    state_reg <= ST_FX_KE2;
                ST_FX_KE2:
                begin
                    ke_reg    <= mres.val;
                    fault_reg <= fault_reg | mres.flag;
                    state_reg <= ST_FX_HK;
                end
                ST_FX_HK:
                begin
                    tmp_reg   <= s_ehk.val;
                    fault_reg <= fault_reg | hk.flag | s_ehk.flag;
                    state_reg <= ST_FX_P;
                end
                ST_FX_P:     state_reg <= ST_FX_P2;
                ST_FX_P2:
                begin
                    p_reg     <= mres.val;
                    fault_reg <= fault_reg | mres.flag;
                    state_reg <= ST_FX_FM;
                end
                ST_FX_FM:
                begin
                    if (side_reg)
                    begin
                        fr_reg[0] <= ru_reg;
                        fr_reg[1] <= s_kep.val;
                    end
                    else
                    begin
                        fl_reg[0] <= ru_reg;
                        fl_reg[1] <= s_kep.val;
                    end
                    tmp_reg   <= s_ep.val;
                    fault_reg <= fault_reg | s_kep.flag | s_ep.flag;
                    state_reg <= ST_FX_FE;
                end
                ST_FX_FE:    state_reg <= ST_FX_FE2;
                ST_FX_FE2:
                begin
                    if (side_reg)
                        fr_reg[2] <= mres.val;
                    else
                        fl_reg[2] <= mres.val;
                    fault_reg <= fault_reg | mres.flag;
                    if (side_reg)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_DL_SUB;
                    end
                    else
                    begin
                        side_reg  <= 1'b1;
                        state_reg <= ST_FX_VEL;
                    end
                end
                ST_DL_SUB:
                begin
                    tmp_reg   <= s_dlt.val;
                    fault_reg <= fault_reg | s_dlt.flag;
                    state_reg <= ST_DL_M;
                end
                ST_DL_M:     state_reg <= ST_DL_M2;
                ST_DL_M2:
                begin
                    p_reg     <= mres.val;
                    fault_reg <= fault_reg | mres.flag;
                    state_reg <= ST_DL_OUT;
                end
                ST_DL_OUT:
                begin
                    rl_reg[k_reg] <= s_ol.val;
                    rr_reg[k_reg] <= s_or.val;
                    fault_reg     <= fault_reg | s_ol.flag | s_or.flag;
                    if (k_reg == 2'd2)
                        state_reg <= ST_DONE;
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= ST_DL_SUB;
                    end
                end
                ST_DONE:
                begin
                    // hold until the output register is free
                    if (!ovalid_reg || face_out.ready)
                    begin
                        o_dl_reg   <= rl_reg[0];
                        o_dr_reg   <= rr_reg[0];
                        o_ml_reg   <= rl_reg[1];
                        o_mr_reg   <= rr_reg[1];
                        o_el_reg   <= rl_reg[2];
                        o_er_reg   <= rr_reg[2];
                        o_f_reg    <= fault_reg;
                        ovalid_reg <= 1'b1;
                        win0_reg   <= win1_reg;
                        win1_reg   <= cur_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase
        end
    end

    assign face_out.valid          = ovalid_reg;
    assign face_out.density_left   = o_dl_reg;
    assign face_out.density_right  = o_dr_reg;
    assign face_out.momentum_left  = o_ml_reg;
    assign face_out.momentum_right = o_mr_reg;
    assign face_out.energy_left    = o_el_reg;
    assign face_out.energy_right   = o_er_reg;
    assign face_out.fault          = o_f_reg;

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_SL_DIVW || state_reg == ST_FX_VW))
        else $error("quotient arrived outside a wait state");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("window count out of range");

endmodule

@@ test/face_checker.sv @@
module face_checker import msh_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    msh_cell_if                  cells,
    msh_face_if                  face,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   fail_count,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        data_t dl, dr, ml, mr, el, er;
        logic  fault;
    } faces_t;

    localparam longint ONE  = 64'sd65536;
    localparam longint SMAX = 64'sd2147483647;
    localparam longint SMIN = -64'sd2147483648;

    faces_t  expected_faces[$];
    longint  win_rho[2], win_mom[2], win_en[2];
    int      cells_held;
    longint  omega, gm1, hdx;
    bit      flagged;

    function automatic longint unsigned magn(longint a);
        return a < 0 ? longint'(-a) : a;
    endfunction

    function automatic longint clip(longint v);
        if (v > SMAX)
        begin
            flagged = 1'b1;
            return SMAX;
        end
        if (v < SMIN)
        begin
            flagged = 1'b1;
            return SMIN;
        end
        return v;
    endfunction

    function automatic longint clip_mag(longint unsigned p, bit neg);
        if (neg)
        begin
            if (p > SMAX)
            begin
                if (p > SMAX + 1) flagged = 1'b1;
                return SMIN;
            end
            return -longint'(p);
        end
        if (p > SMAX)
        begin
            flagged = 1'b1;
            return SMAX;
        end
        return longint'(p);
    endfunction

    function automatic longint fmul(longint a, longint b);
        longint unsigned p;
        p = (magn(a) * magn(b)) >> 16;
        return clip_mag(p, ((a < 0) != (b < 0)) && p != 0);
    endfunction

    function automatic longint half_slope(longint l, longint c, longint r);
        longint a, b, w;
        longint unsigned ua, ub, q, ml, m;
        a = c - l;
        b = r - c;
        if (a == 0 || b == 0 || ((a < 0) != (b < 0))) return 0;
        w = omega;
        if (w > ONE) w = ONE;
        if (w < -ONE) w = -ONE;
        ua = magn(a);
        ub = magn(b);
        q  = (longint'(ONE + w) * ua + longint'(ONE - w) * ub) / (ua + ub);
        ml = (q * ua) >> 16;
        m  = (ml < ub ? ml : ub) >> 1;
        return a < 0 ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint speed(longint rho, longint m);
        if (rho <= 0)
        begin
            flagged = 1'b1;
            return m > 0 ? SMAX : (m < 0 ? SMIN : 0);
        end
        return clip_mag((magn(m) << 16) / longint'(rho), m < 0);
    endfunction

    // Flux of one face: mass, momentum, energy.
    task automatic face_flux(input longint r, m, e, output longint fr, fm, fe);
        longint u, ru, ke, hk, p;
        u  = speed(r, m);
        ru = fmul(r, u);
        ke = fmul(ru, u);
        hk = clip_mag(magn(ke) >> 1, ke < 0);
        p  = fmul(gm1, clip(e - hk));
        fr = ru;
        fm = clip(ke + p);
        fe = fmul(u, clip(e + p));
    endtask

    task automatic predict_faces(input logic first, input data_t d, m, e);
        longint hr, hm, he, lr, rr, lm, rm, le, re;
        longint flr, flm, fle, frr, frm, fre, dr, dm, de;
        faces_t x;
        if (first)
        begin
            win_rho = '{0, 0};
            win_mom = '{0, 0};
            win_en  = '{0, 0};
            cells_held = 0;
        end
        if (cells_held >= 2)
        begin
            flagged = 1'b0;
            hr = half_slope(win_rho[0], win_rho[1], d);
            hm = half_slope(win_mom[0], win_mom[1], m);
            he = half_slope(win_en[0], win_en[1], e);
            lr = clip(win_rho[1] - hr);
            rr = clip(win_rho[1] + hr);
            lm = clip(win_mom[1] - hm);
            rm = clip(win_mom[1] + hm);
            le = clip(win_en[1] - he);
            re = clip(win_en[1] + he);
            face_flux(lr, lm, le, flr, flm, fle);
            face_flux(rr, rm, re, frr, frm, fre);
            dr = fmul(hdx, clip(flr - frr));
            dm = fmul(hdx, clip(flm - frm));
            de = fmul(hdx, clip(fle - fre));
            x.dl = data_t'(clip(lr + dr));
            x.dr = data_t'(clip(rr + dr));
            x.ml = data_t'(clip(lm + dm));
            x.mr = data_t'(clip(rm + dm));
            x.el = data_t'(clip(le + de));
            x.er = data_t'(clip(re + de));
            x.fault = flagged;
            expected_faces.push_back(x);
        end
        win_rho[0] = win_rho[1];
        win_mom[0] = win_mom[1];
        win_en[0]  = win_en[1];
        win_rho[1] = d;
        win_mom[1] = m;
        win_en[1]  = e;
        if (cells_held < 2) cells_held++;
    endtask

    task automatic cmp(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        faces_t x;
        if (!rst_n)
        begin
            win_rho = '{0, 0};
            win_mom = '{0, 0};
            win_en  = '{0, 0};
            cells_held = 0;
            omega = 0;
            gm1   = 26214;
            hdx   = 0;
            expected_faces.delete();
            fail_count = 0;
        end
        else
        begin
            if (face.valid && face.ready)
            begin
                if (expected_faces.size() == 0)
                begin
                    $error("face item with nothing expected");
                    fail_count++;
                end
                else
                begin
                    x = expected_faces.pop_front();
                    cmp("density_left", x.dl, face.density_left);
                    cmp("density_right", x.dr, face.density_right);
                    cmp("momentum_left", x.ml, face.momentum_left);
                    cmp("momentum_right", x.mr, face.momentum_right);
                    cmp("energy_left", x.el, face.energy_left);
                    cmp("energy_right", x.er, face.energy_right);
                    cmp("fault", x.fault, face.fault);
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_OMEGA: omega = longint'(signed'(cfg_data));
                    REG_GAMMA: gm1   = longint'(cfg_data);
                    REG_HDX:   hdx   = longint'(cfg_data[16:0]);
                    default: ;
                endcase
            end
            if (cells.valid && cells.ready)
                predict_faces(cells.first_cell, cells.density, cells.momentum,
                              cells.energy);
        end
        pending = expected_faces.size();
    end
endmodule

@@ test/tb_top.sv @@
module tb_top;
    import msh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE      = 400;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   fail_count;
    int                   pending;
    int                   items_sent;
    int                   idle_stall;
    int                   rx_cycle;

    msh_cell_if cells ();
    msh_face_if face ();

    muscl_hancock_cell_predictor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_in   (cells),
        .face_out  (face),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    face_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cells      (cells),
        .face       (face),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    // Hold off idling for a stretch of items so the block runs back to back.
    task automatic send_cell(input logic first, input data_t d, m, e);
        while (!(items_sent >= 200 && items_sent < 300) && $urandom_range(99) < 17)
        begin
            cells.valid <= 1'b0;
            @(posedge clk);
        end
        cells.valid      <= 1'b1;
        cells.first_cell <= first;
        cells.density    <= d;
        cells.momentum   <= m;
        cells.energy     <= e;
        do @(posedge clk); while (!cells.ready);
        items_sent++;
    endtask

    task automatic drain();
        cells.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_settings(input logic [CFG_W-1:0] w, g, h);
        cfg_we <= 1'b1; cfg_index <= REG_OMEGA; cfg_data <= w;
        @(posedge clk);
        cfg_index <= REG_GAMMA; cfg_data <= g;
        @(posedge clk);
        cfg_index <= REG_HDX; cfg_data <= h;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic data_t jitter(data_t base, int span);
        return base + data_t'($urandom_range(2 * span) - span);
    endfunction

    task automatic random_phase(input int count);
        int    len;
        data_t d, m, e;
        while (count > 0)
        begin
            if ($urandom_range(99) < 20)
            begin
                send_cell(1'($urandom_range(1)), $urandom, $urandom, $urandom);
                count--;
            end
            else
            begin
                len = $urandom_range(3, 12);
                d = data_t'($urandom_range(1 << 20, 1 << 12));
                m = data_t'($urandom_range(1 << 20)) - data_t'(1 << 19);
                e = data_t'($urandom_range(1 << 23, 1 << 14));
                for (int i = 0; i < len; i++)
                begin
                    if ($urandom_range(99) < 5)
                        send_cell(1'b0, $urandom, $urandom, $urandom);
                    else
                        send_cell(i == 0, d, m, e);
                    d = jitter(d, 8192);
                    m = jitter(m, 16384);
                    e = jitter(e, 65536);
                end
                count -= len;
            end
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_OMEGA;
        cfg_data         <= '0;
        cells.valid      <= 1'b0;
        cells.first_cell <= 1'b0;
        cells.density    <= '0;
        cells.momentum   <= '0;
        cells.energy     <= '0;
        items_sent       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Omega beyond one gets clamped; the spare index is ignored.
        cfg_we <= 1'b1; cfg_index <= 2'd3; cfg_data <= '1;
        @(posedge clk);
        write_settings(18'h1FFFF, 18'd26214, 18'd20000);

        send_cell(1'b1, 32'sd65536, 32'sd0, 32'sd65536);
        send_cell(1'b0, 32'sd131072, 32'sd65536, 32'sd200000);
        send_cell(1'b0, 32'sd262144, 32'sd131072, 32'sd500000);
        send_cell(1'b0, 32'sd300000, -32'sd65536, 32'sd600000);
        send_cell(1'b1, 32'sd0, 32'sd0, 32'sd0);
        send_cell(1'b0, 32'sd0, 32'sd0, 32'sd0);
        send_cell(1'b0, 32'sd0, 32'sd0, 32'sd0);
        send_cell(1'b1, DMAX, DMAX, DMAX);
        send_cell(1'b0, DMIN, DMIN, DMIN);
        send_cell(1'b0, DMAX, DMIN, DMAX);
        send_cell(1'b0, DMIN, DMAX, DMIN);
        send_cell(1'b1, -32'sd65536, 32'sd65536, 32'sd0);
        send_cell(1'b0, -32'sd65536, -32'sd65536, 32'sd0);
        send_cell(1'b0, 32'sd0, 32'sd0, 32'sd100);
        send_cell(1'b0, 32'sd0, 32'sd5, 32'sd5);
        send_cell(1'b1, 32'sd65536, 32'sd1000, 32'sd65536);
        send_cell(1'b0, 32'sd65536, 32'sd1000, 32'sd65536);
        send_cell(1'b0, 32'sd131072, 32'sd2000, 32'sd90000);
        send_cell(1'b0, 32'sd131072, 32'sd500, 32'sd90000);
        send_cell(1'b0, 32'sd65536, 32'sd3000, 32'sd40000);
        drain();

        write_settings(18'h20000, 18'd100000, 18'd65536);
        random_phase(100);
        drain();
        write_settings(18'd0, 18'd26214, 18'd32768);
        random_phase(100);
        drain();
        write_settings(18'd65536, 18'd131072, 18'd65536);
        random_phase(100);
        drain();
        write_settings(-18'sd65536, 18'd0, 18'd0);
        random_phase(100);
        drain();
        write_settings(CFG_W'($urandom), CFG_W'($urandom_range(131072)),
                       CFG_W'($urandom_range(65536)));
        random_phase(100);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Result side: random back-pressure, one long hold-off, one long open stretch.
    initial
    begin
        face.ready <= 1'b0;
        rx_cycle = 0;
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (rx_cycle >= 30000 && rx_cycle < 33000)
                face.ready <= 1'b0;
            else if (rx_cycle >= 60000 && rx_cycle < 100000)
                face.ready <= 1'b1;
            else
                face.ready <= ($urandom_range(99) >= 17);
        end
    end

    initial
    begin
        idle_stall = 0;
        forever
        begin
            @(posedge clk);
            if ((cells.valid && cells.ready) || (face.valid && face.ready))
                idle_stall = 0;
            else
                idle_stall++;
            if (idle_stall >= STALL_LIMIT)
            begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end
endmodule
